### src/euv_pkg.sv
// ----------------------------------------------------------------------------
// euv_pkg
// Shared types and constants for the encoder unwrap and velocity block.
// ----------------------------------------------------------------------------
package euv_pkg;

  localparam int unsigned ANGLE_BITS_DEF = 14;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned RAW_W          = 16;
  localparam int unsigned TS_W           = 32;
  localparam int unsigned POS_W          = 32;
  localparam int unsigned VEL_W          = 24;
  localparam int unsigned DIV_W          = 32;
  localparam int unsigned DIV_STEPS      = DIV_W;
  localparam int unsigned CNT_W          = $clog2(DIV_STEPS);
  localparam logic [DIV_W-1:0] VEL_SCALE = DIV_W'(1000);

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE    = 2'd0,
    OP_SET_ZERO  = 2'd1,
    OP_RESET_POS = 2'd2,
    OP_COMMUTATE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MUL,
    ST_DIV,
    ST_COMMIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic step;
    logic mul;
    logic div_iter;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic query;
    logic dt_zero;
  } ctrl_status_t;

endpackage

### src/encoder_unwrap_velocity.sv
// ----------------------------------------------------------------------------
// encoder_unwrap_velocity
// Multi-turn unwrap, position and velocity for an absolute angle sensor.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one word: opcode, raw sensor
// word and microsecond timestamp. Output channel (out_valid_o / out_stall_i)
// returns one word per input: angle, position, velocity, commutation angle
// and the divide-by-zero flag.
// Sequence: a sample word with nonzero elapsed time passes through the step,
// multiply, divide (the 32-step serial divider), commit and emit states; a
// sample with zero elapsed time skips the divide, and a commutation query goes
// from step straight to emit. One word is in flight at a time.
// The result sits in an output register; a new input word is taken while
// that result waits. A finished result waits in the emit state while the
// output register is still full and stalled.
// The user writes electrical_zero (cfg_we_i / cfg_data_i) only while idle;
// the block does not enforce this. Reset (rst_ni low, asynchronous) clears
// all tracking state, the electrical zero and the output valid flag.
// ----------------------------------------------------------------------------
module encoder_unwrap_velocity import euv_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ANGLE_BITS-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [RAW_W-1:0]        raw_word_i,
  input  logic [TS_W-1:0]         timestamp_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ANGLE_BITS-1:0]   angle_o,
  output logic signed [POS_W-1:0] position_o,
  output logic signed [VEL_W-1:0] velocity_o,
  output logic [ANGLE_BITS-1:0]   commutation_angle_o,
  output logic                    divide_by_zero_o
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  euv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  euv_dpath #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_data_i         (cfg_data_i),
    .opcode_i           (opcode_i),
    .raw_word_i         (raw_word_i),
    .timestamp_i        (timestamp_i),
    .angle_o            (angle_o),
    .position_o         (position_o),
    .velocity_o         (velocity_o),
    .commutation_angle_o(commutation_angle_o),
    .divide_by_zero_o   (divide_by_zero_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while a word is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("output register overwritten while stalled");

  a_dz_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && divide_by_zero_o) |-> (velocity_o == '0))
    else $error("nonzero velocity with zero elapsed time");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

### src/euv_ctrl.sv
// ----------------------------------------------------------------------------
// euv_ctrl
// Sequencer: steps one word through unwrap, scale, divide, commit and emit.
// ----------------------------------------------------------------------------
module euv_ctrl import euv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = status_i.query ? ST_EMIT : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = CNT_W'(DIV_STEPS - 1);
        state_d   = status_i.dt_zero ? ST_COMMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_iter = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_COMMIT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.emit | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != ST_IDLE);

endmodule

### src/euv_dpath.sv
// ----------------------------------------------------------------------------
// euv_dpath
// Datapath: angle unwrap, saturating position, serial velocity divider,
// tracking state and the output register.
// ----------------------------------------------------------------------------
module euv_dpath import euv_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output ctrl_status_t            status_o,
  input  logic                    cfg_we_i,
  input  logic [ANGLE_BITS-1:0]   cfg_data_i,
  input  logic [OP_W-1:0]         opcode_i,
  input  logic [RAW_W-1:0]        raw_word_i,
  input  logic [TS_W-1:0]         timestamp_i,
  output logic [ANGLE_BITS-1:0]   angle_o,
  output logic signed [POS_W-1:0] position_o,
  output logic signed [VEL_W-1:0] velocity_o,
  output logic [ANGLE_BITS-1:0]   commutation_angle_o,
  output logic                    divide_by_zero_o
);

  localparam int unsigned AW = ANGLE_BITS;
  localparam logic signed [AW+1:0] HALF_S = (AW+2)'(1) <<< (AW - 1);
  localparam logic signed [AW+1:0] RES_S  = (AW+2)'(1) <<< AW;
  localparam logic signed [POS_W:0] POS_MAX_S = {2'b00, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W:0] POS_MIN_S = {2'b11, {(POS_W-1){1'b0}}};
  localparam logic signed [DIV_W:0] VEL_MAX_S = (DIV_W+1)'((1 << (VEL_W - 1)) - 1);
  localparam logic signed [DIV_W:0] VEL_MIN_S = -(DIV_W+1)'(1 << (VEL_W - 1));

  // captured word
  op_e                op_q;
  logic [AW-1:0]      ang_q;
  logic [TS_W-1:0]    ts_q;

  // working registers
  logic signed [AW:0] step_q;
  logic [TS_W-1:0]    dt_q;
  logic               dtz_q;
  logic [DIV_W-1:0]   quo_q, rem_q, dsr_q;
  logic               neg_q;

  // tracked state
  logic [AW-1:0]           ez_q;
  logic [AW-1:0]           cur_q;
  logic [TS_W-1:0]         prev_time_q;
  logic signed [POS_W-1:0] acc_q;
  logic [AW-1:0]           zero_q, reset_q;
  logic signed [VEL_W-1:0] vel_q;

  // direction reversal of the sensor angle
  logic [AW+RAW_W-1:0] raw_ext;
  logic [AW-1:0]       ang_in;
  assign raw_ext = {{AW{1'b0}}, raw_word_i};
  assign ang_in  = '0 - raw_ext[AW-1:0];

  // unwrap into half a turn either way
  logic signed [AW+1:0] diff_w, step_w;
  assign diff_w = $signed({2'b00, ang_q}) - $signed({2'b00, cur_q});
  always_comb begin
    priority if (diff_w > HALF_S)  step_w = diff_w - RES_S;
    else if (diff_w < -HALF_S)     step_w = diff_w + RES_S;
    else                           step_w = diff_w;
  end

  logic [TS_W-1:0] dt_w;
  assign dt_w = ts_q - prev_time_q;

  // magnitudes for the unsigned divider
  logic [AW:0]      step_mag;
  logic [DIV_W-1:0] step_ext, dt_mag;
  assign step_mag = step_q[AW] ? (AW+1)'(0) - step_q : step_q;
  assign step_ext = {{(DIV_W-AW-1){1'b0}}, step_mag};
  assign dt_mag   = dt_q[TS_W-1] ? '0 - dt_q : dt_q;

  // one restoring step
  logic [DIV_W:0] rem_sh, trial;
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign trial  = rem_sh - {1'b0, dsr_q};

  // saturating accumulate
  logic signed [POS_W:0] sum_w;
  logic signed [POS_W-1:0] acc_sat;
  assign sum_w = {acc_q[POS_W-1], acc_q} + {{(POS_W-AW){step_q[AW]}}, step_q};
  always_comb begin
    priority if (sum_w > POS_MAX_S) acc_sat = POS_MAX_S[POS_W-1:0];
    else if (sum_w < POS_MIN_S)     acc_sat = POS_MIN_S[POS_W-1:0];
    else                            acc_sat = sum_w[POS_W-1:0];
  end

  // signed quotient clamped to the velocity range
  logic signed [DIV_W:0]   qs_w;
  logic signed [VEL_W-1:0] vel_sat;
  assign qs_w = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  always_comb begin
    priority if (qs_w > VEL_MAX_S) vel_sat = VEL_MAX_S[VEL_W-1:0];
    else if (qs_w < VEL_MIN_S)     vel_sat = VEL_MIN_S[VEL_W-1:0];
    else                           vel_sat = qs_w[VEL_W-1:0];
  end

  // reported position: accumulation less the datum offset, saturated
  logic signed [AW:0]      off_w;
  logic signed [POS_W+1:0] pos_w;
  logic signed [POS_W-1:0] pos_sat;
  assign off_w = $signed({1'b0, zero_q}) - $signed({1'b0, reset_q});
  assign pos_w = {{2{acc_q[POS_W-1]}}, acc_q} - {{(POS_W+1-AW){off_w[AW]}}, off_w};
  always_comb begin
    priority if (pos_w > $signed({POS_MAX_S[POS_W], POS_MAX_S}))
      pos_sat = POS_MAX_S[POS_W-1:0];
    else if (pos_w < $signed({POS_MIN_S[POS_W], POS_MIN_S}))
      pos_sat = POS_MIN_S[POS_W-1:0];
    else
      pos_sat = pos_w[POS_W-1:0];
  end

  assign status_o.query   = (op_q == OP_COMMUTATE);
  assign status_o.dt_zero = dtz_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(opcode_i);
      ang_q <= ang_in;
      ts_q  <= timestamp_i;
    end
    if (cmd_i.step) begin
      step_q <= step_w[AW:0];
      dt_q   <= dt_w;
      dtz_q  <= (dt_w == '0);
    end
    if (cmd_i.mul) begin
      quo_q <= step_ext * VEL_SCALE;
      rem_q <= '0;
      dsr_q <= dt_mag;
      neg_q <= step_q[AW] ^ dt_q[TS_W-1];
    end else if (cmd_i.div_iter) begin
      if (!trial[DIV_W]) begin
        rem_q <= trial[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DIV_W-1:0];
        quo_q <= {quo_q[DIV_W-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      angle_o             <= cur_q - zero_q;
      position_o          <= pos_sat;
      velocity_o          <= vel_q;
      commutation_angle_o <= (op_q == OP_COMMUTATE) ? ang_q - ez_q : '0;
      divide_by_zero_o    <= (op_q != OP_COMMUTATE) & dtz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ez_q        <= '0;
      cur_q       <= '0;
      prev_time_q <= '0;
      acc_q       <= '0;
      zero_q      <= '0;
      reset_q     <= '0;
      vel_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        ez_q <= cfg_data_i;
      end
      if (cmd_i.commit && op_q != OP_COMMUTATE) begin
        cur_q       <= ang_q;
        prev_time_q <= ts_q;
        vel_q       <= dtz_q ? '0 : vel_sat;
        unique case (op_q)
          OP_SET_ZERO: begin
            acc_q   <= '0;
            zero_q  <= ang_q;
            reset_q <= ang_q;
          end
          OP_RESET_POS: begin
            acc_q   <= '0;
            reset_q <= ang_q;
          end
          default: acc_q <= acc_sat;
        endcase
      end
    end
  end

endmodule
